>>> rtl/pqa_pkg.sv
`default_nettype none
package pqa_pkg;

	localparam logic [1:0] ACT_REGISTER   = 2'd0;
	localparam logic [1:0] ACT_UNREGISTER = 2'd1;
	localparam logic [1:0] ACT_CLEAR      = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_GLOBAL  = 3'd2;
	localparam logic [2:0] ST_IDS     = 3'd3;
	localparam logic [2:0] ST_PER_ID  = 3'd4;

	localparam logic [1:0] CFG_TOTAL_LIMIT  = 2'd0;
	localparam logic [1:0] CFG_PER_ID_LIMIT = 2'd1;
	localparam logic [1:0] CFG_ID_LIMIT     = 2'd2;

	localparam logic [31:0] TOTAL_LIMIT_RST  = 32'd20971520;
	localparam logic [31:0] PER_ID_LIMIT_RST = 32'd1048576;
	localparam logic [7:0]  ID_LIMIT_RST     = 8'd100;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] owner_id;
		logic [31:0]        amount;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  pressure;
		logic [31:0] total_bytes;
		logic [7:0]  active_count;
	} rsp_t;

	// Search token handed from cell to cell.
	typedef struct packed {
		logic        active;
		logic        hit;
		logic [31:0] usage;
		logic        free;
	} link_t;

	// Write command broadcast to the row.
	typedef struct packed {
		logic        wr;
		logic        clr;
		logic        valid;
		logic [30:0] id;
		logic [31:0] usage;
	} wcmd_t;

endpackage
`default_nettype wire

>>> rtl/pqa_cell.sv
`default_nettype none
module pqa_cell #(
	parameter int IW  = 7,
	parameter int IDX = 0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire  [30:0]         key,
	input  pqa_pkg::link_t      link_in,
	input  wire  [IW-1:0]       hit_idx_in,
	input  wire  [IW-1:0]       free_idx_in,
	output pqa_pkg::link_t      link_out,
	output logic [IW-1:0]       hit_idx_out,
	output logic [IW-1:0]       free_idx_out,
	input  pqa_pkg::wcmd_t      wcmd,
	input  wire  [IW-1:0]       widx
);
	import pqa_pkg::*;

	logic        valid_q;
	logic [30:0] id_q;
	logic [31:0] usage_q;
	logic        my_hit;
	logic        my_free;

	assign my_hit  = valid_q && (id_q == key);
	assign my_free = !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wcmd.clr) begin
			valid_q <= 1'b0;
		end else if (wcmd.wr && (widx == IW'(IDX))) begin
			valid_q <= wcmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wcmd.wr && !wcmd.clr && (widx == IW'(IDX))) begin
			id_q    <= wcmd.id;
			usage_q <= wcmd.usage;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_out <= '0;
		end else begin
			link_out.active <= link_in.active;
			link_out.hit    <= link_in.hit || my_hit;
			link_out.free   <= link_in.free || my_free;
			link_out.usage  <= link_in.hit ? link_in.usage : usage_q;
		end
	end

	// The lowest matching and lowest free positions win.
	always_ff @(posedge clk) begin
		hit_idx_out  <= link_in.hit ? hit_idx_in : IW'(IDX);
		free_idx_out <= link_in.free ? free_idx_in : IW'(IDX);
	end

endmodule
`default_nettype wire

>>> rtl/per_id_quota_accountant.sv
// Register and unregister requests pass S_SCAN (the search token walks the whole row of
// cells, one cell per cycle), S_APPLY, S_MUL, S_CMP; clear and invalid requests take S_MUL, S_CMP.
// One request at a time: busy stays high from acceptance until the done strobe.
// The result is shown for one cycle with done high; the receiver cannot stall it.
// Configuration writes are held off while a request is in flight.
// Asynchronous active-low reset empties the table and restores the register defaults.
`default_nettype none
module per_id_quota_accountant #(
	parameter int TABLE_DEPTH = 128
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  pqa_pkg::req_t      req,
	output logic               done,
	output pqa_pkg::rsp_t      result,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire  [1:0]         cfg_index,
	input  wire  [31:0]        cfg_data
);
	import pqa_pkg::*;

	localparam int IW  = $clog2(TABLE_DEPTH);
	localparam int CW  = $clog2(TABLE_DEPTH + 1);
	localparam int CMW = (CW > 8) ? CW : 8;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_APPLY = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_CMP   = 3'd4;

	logic [2:0]    state_q;
	req_t          req_q;
	logic          tok_q;
	logic [31:0]   total_limit_q, per_id_limit_q;
	logic [7:0]    id_limit_q;
	logic [31:0]   global_q;
	logic [CW-1:0] live_q;
	logic [2:0]    status_q;
	logic          hit_q, free_q;
	logic [31:0]   usage_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;
	wcmd_t         wcmd_q;
	logic [IW-1:0] widx_q;
	logic [38:0]   g100_s1, l91_s1, l76_s1, l51_s1;

	link_t         link   [TABLE_DEPTH+1];
	logic [IW-1:0] hidx   [TABLE_DEPTH+1];
	logic [IW-1:0] fidx   [TABLE_DEPTH+1];

	logic          id_ok, req_ok;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign id_ok     = (req.owner_id != 32'sd0) && !req.owner_id[31];
	assign req_ok    = id_ok && (req.amount != 32'd0);

	assign link[0] = '{active: tok_q, hit: 1'b0, usage: 32'd0, free: 1'b0};
	assign hidx[0] = '0;
	assign fidx[0] = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		pqa_cell #(.IW(IW), .IDX(i)) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.key          (req_q.owner_id[30:0]),
			.link_in      (link[i]),
			.hit_idx_in   (hidx[i]),
			.free_idx_in  (fidx[i]),
			.link_out     (link[i+1]),
			.hit_idx_out  (hidx[i+1]),
			.free_idx_out (fidx[i+1]),
			.wcmd         (wcmd_q),
			.widx         (widx_q)
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_limit_q  <= TOTAL_LIMIT_RST;
			per_id_limit_q <= PER_ID_LIMIT_RST;
			id_limit_q     <= ID_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TOTAL_LIMIT:  total_limit_q  <= cfg_data;
				CFG_PER_ID_LIMIT: per_id_limit_q <= cfg_data;
				CFG_ID_LIMIT:     id_limit_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Decision logic for the apply step.
	logic [32:0]    sum_g;
	logic [32:0]    sum_u;
	logic [31:0]    cur_u;
	logic [CMW-1:0] cap, live_ext;
	logic [31:0]    rel, rel2, new_u;

	always_comb begin
		cur_u    = hit_q ? usage_q : 32'd0;
		sum_g    = {1'b0, global_q} + {1'b0, req_q.amount};
		sum_u    = {1'b0, cur_u} + {1'b0, req_q.amount};
		live_ext = CMW'(live_q);
		cap      = (CMW'(id_limit_q) < CMW'(TABLE_DEPTH)) ? CMW'(id_limit_q)
			: CMW'(TABLE_DEPTH);
		rel      = (hit_q && (usage_q < req_q.amount)) ? usage_q : req_q.amount;
		new_u    = usage_q - rel;
		rel2     = (global_q < rel) ? global_q : rel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			tok_q      <= 1'b0;
			done       <= 1'b0;
			global_q   <= '0;
			live_q     <= '0;
			wcmd_q     <= '0;
			req_q      <= '0;
			status_q   <= ST_OK;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			usage_q    <= '0;
			hit_idx_q  <= '0;
			free_idx_q <= '0;
			widx_q     <= '0;
		end else begin
			tok_q  <= 1'b0;
			done   <= 1'b0;
			wcmd_q <= '0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q    <= req;
						status_q <= ST_OK;
						if ((req.action == ACT_REGISTER || req.action == ACT_UNREGISTER)
							&& req_ok) begin
							tok_q   <= 1'b1;
							state_q <= S_SCAN;
						end else if (req.action == ACT_CLEAR) begin
							wcmd_q.clr <= 1'b1;
							global_q   <= '0;
							live_q     <= '0;
							state_q    <= S_MUL;
						end else begin
							status_q <= ST_INVALID;
							state_q  <= S_MUL;
						end
					end
				end
				S_SCAN: begin
					if (link[TABLE_DEPTH].active) begin
						hit_q      <= link[TABLE_DEPTH].hit;
						free_q     <= link[TABLE_DEPTH].free;
						usage_q    <= link[TABLE_DEPTH].usage;
						hit_idx_q  <= hidx[TABLE_DEPTH];
						free_idx_q <= fidx[TABLE_DEPTH];
						state_q    <= S_APPLY;
					end
				end
				S_APPLY: begin
					state_q <= S_MUL;
					wcmd_q.id <= req_q.owner_id[30:0];
					if (req_q.action == ACT_REGISTER) begin
						priority if (sum_g > {1'b0, total_limit_q}) begin
							status_q <= ST_GLOBAL;
						end else if (!hit_q && (live_ext >= cap || !free_q)) begin
							status_q <= ST_IDS;
						end else if (sum_u > {1'b0, per_id_limit_q}) begin
							status_q <= ST_PER_ID;
						end else begin
							wcmd_q.wr    <= 1'b1;
							wcmd_q.valid <= 1'b1;
							wcmd_q.usage <= sum_u[31:0];
							widx_q       <= hit_q ? hit_idx_q : free_idx_q;
							global_q     <= sum_g[31:0];
							if (!hit_q) live_q <= live_q + CW'(1);
						end
					end else begin
						if (hit_q) begin
							wcmd_q.wr    <= 1'b1;
							wcmd_q.valid <= (new_u != 32'd0);
							wcmd_q.usage <= new_u;
							widx_q       <= hit_idx_q;
							if (new_u == 32'd0 && live_q != '0) live_q <= live_q - CW'(1);
						end
						global_q <= global_q - rel2;
					end
				end
				S_MUL: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// floor(g*100/L) > k is the same as g*100 >= (k+1)*L; a zero limit lands on critical.
	always_ff @(posedge clk) begin
		g100_s1 <= 39'(global_q) * 39'd100;
		l91_s1  <= 39'(total_limit_q) * 39'd91;
		l76_s1  <= 39'(total_limit_q) * 39'd76;
		l51_s1  <= 39'(total_limit_q) * 39'd51;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CMP) begin
			result.status       <= status_q;
			result.total_bytes  <= global_q;
			result.active_count <= 8'(live_q);
			priority if (g100_s1 >= l91_s1) result.pressure <= 2'd3;
			else if (g100_s1 >= l76_s1)     result.pressure <= 2'd2;
			else if (g100_s1 >= l51_s1)     result.pressure <= 2'd1;
			else                            result.pressure <= 2'd0;
		end
	end

endmodule
`default_nettype wire
